// ===== rtl/core/text_terminal_overlay_top_defines.svh =====
// assertion macros of the text overlay rtl, used by the back end
`ifndef TEXT_TERMINAL_OVERLAY_TOP_DEFINES_SVH
`define TEXT_TERMINAL_OVERLAY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TTO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TTO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TTO_ASSERT_IMP(lbl, ante, cons)
`define TTO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/tto_pkg.sv =====
// shared constants and types of the text overlay
package tto_pkg;
    localparam int COLUMNS       = 40;
    localparam int ROWS          = 25;
    localparam int LAST_TEXT_ROW = 24;
    localparam int GLYPH_WIDTH   = 8;
    localparam int GLYPH_HEIGHT  = 8;
    localparam int SCREEN_WIDTH  = 320;
    localparam int CELL_COUNT    = COLUMNS * ROWS;
    localparam int CELL_AW       = $clog2(CELL_COUNT);
    localparam int FONT_DEPTH    = 2048;
    localparam int FONT_AW       = 11;
    localparam int CELL_W        = 11;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;
    localparam int GX_W          = $clog2(GLYPH_WIDTH) > 0 ? $clog2(GLYPH_WIDTH) : 1;
    localparam int GY_W          = $clog2(GLYPH_HEIGHT) > 0 ? $clog2(GLYPH_HEIGHT) : 1;

    localparam logic [2:0]        EMPTY_MARK = 3'd4;
    localparam logic [CELL_W-1:0] BLANK_CELL = {3'd4, 8'd4};

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_FONT   = 2'd2;
    localparam logic [1:0] KIND_RENDER = 2'd3;

    // classified item as it waits in the queue
    typedef struct packed {
        logic [1:0]         kind;
        logic               scroll;
        logic               blank_all;
        logic [CELL_AW-1:0] scroll_off;
        logic               wr_ok;
        logic [CELL_AW-1:0] cell_idx;
        logic [CELL_W-1:0]  cell_data;
        logic [FONT_AW-1:0] font_addr;
        logic [7:0]         font_byte;
        logic               pass;
        logic [8:0]         pix_x;
        logic [7:0]         pix_y;
        logic [7:0]         under;
    } op_t;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } back_stat_t;
endpackage

// ===== rtl/core/tto_front.sv =====
// front end: accepts items, classifies them and queues them
module tto_front import tto_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // col[7:0] row[15:8] code[23:16] flags[26:24] faddr[37:27] fbyte[45:38]
    // x[54:46] y[62:55] under[70:63]
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,   // kind
    input  back_stat_t  stat,
    output logic        head_valid,
    output op_t         head
);
    op_t                 q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    op_t                 op;
    logic                push;
    logic [7:0]          col, row, lines, final_row;
    logic [8:0]          px;
    logic [7:0]          py;
    logic [5:0]          pcol;
    logic [4:0]          prow;

    always_comb begin
        col       = s_tdata[7:0];
        row       = s_tdata[15:8];
        px        = s_tdata[54:46];
        py        = s_tdata[62:55];
        lines     = row - 8'(LAST_TEXT_ROW);
        pcol      = 6'(px / GLYPH_WIDTH);
        prow      = 5'(py / GLYPH_HEIGHT);
        op.kind   = s_tuser;
        op.scroll = (s_tuser == KIND_WRITE) && (row > 8'(LAST_TEXT_ROW)) && s_tdata[26];
        op.blank_all  = (s_tuser == KIND_CLEAR) || ({24'd0, lines} >= ROWS);
        op.scroll_off = CELL_AW'(32'(lines) * COLUMNS);
        final_row     = op.scroll ? 8'(LAST_TEXT_ROW) : row;
        op.wr_ok      = ({24'd0, col} < COLUMNS) && ({24'd0, final_row} < ROWS);
        op.cell_data  = {1'b0, s_tdata[25:24], s_tdata[23:16]};
        op.font_addr  = s_tdata[37:27];
        op.font_byte  = s_tdata[45:38];
        op.pass       = ({23'd0, px} >= SCREEN_WIDTH) || ({26'd0, pcol} >= COLUMNS)
                        || ({27'd0, prow} >= ROWS);
        op.pix_x      = px;
        op.pix_y      = py;
        op.under      = s_tdata[70:63];
        if (s_tuser == KIND_RENDER) begin
            op.cell_idx = CELL_AW'(32'(prow) * COLUMNS + 32'(pcol));
        end else begin
            op.cell_idx = CELL_AW'(32'(final_row) * COLUMNS + 32'(col));
        end
    end

    assign s_tready   = (count_reg < (QUEUE_AW+1)'(QUEUE_DEPTH)) && !stat.init_busy;
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (stat.pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(stat.pop);
        end
    end
endmodule

// ===== rtl/core/tto_back.sv =====
// back end: cell and font stores, scroll and clear sweeps, pixel render
`include "text_terminal_overlay_top_defines.svh"
module tto_back import tto_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  op_t         head,
    output back_stat_t  stat,
    input  logic [7:0]  fg_color,
    input  logic [7:0]  bg_color,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // pixel_color
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_CELL  = 3'd4;
    localparam logic [2:0] ST_FONT  = 3'd5;

    logic [CELL_W-1:0]  cell_mem [CELL_COUNT];
    logic [7:0]         font_mem [FONT_DEPTH];

    logic [2:0]         state_reg, state_next;
    logic               init_reg, init_next;
    logic [CELL_AW-1:0] cnt_reg, cnt_next;
    logic [CELL_AW-1:0] off_reg, off_next;
    logic               blank_all_reg, blank_all_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [CELL_AW-1:0] wr_idx_reg, wr_idx_next;
    logic               wr_blank_reg, wr_blank_next;
    logic               tgt_ok_reg, tgt_ok_next;
    logic [CELL_AW-1:0] tgt_idx_reg, tgt_idx_next;
    logic [CELL_W-1:0]  tgt_data_reg, tgt_data_next;
    logic               pass_reg, pass_next;
    logic [1:0]         attr_reg, attr_next;
    logic [GX_W-1:0]    x_lo_reg, x_lo_next;
    logic [GY_W-1:0]    y_lo_reg, y_lo_next;
    logic [7:0]         under_reg, under_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_data_reg, m_data_next;

    logic [CELL_W-1:0]  cell_q;
    logic [7:0]         glyph_q;
    logic               cell_we, cell_re, font_we, font_re, pop;
    logic [CELL_AW-1:0] cell_waddr, cell_raddr;
    logic [CELL_W-1:0]  cell_wdata;
    logic [FONT_AW-1:0] font_raddr;
    logic [CELL_AW:0]   src;
    logic               from_src, gbit;

    always_ff @(posedge aclk) begin
        if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
        if (cell_re) cell_q <= cell_mem[cell_raddr];
    end

    always_ff @(posedge aclk) begin
        if (font_we) font_mem[head.font_addr] <= head.font_byte;
        if (font_re) glyph_q <= font_mem[font_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        cnt_next       = cnt_reg;
        off_next       = off_reg;
        blank_all_next = blank_all_reg;
        wr_pend_next   = 1'b0;
        wr_idx_next    = wr_idx_reg;
        wr_blank_next  = wr_blank_reg;
        tgt_ok_next    = tgt_ok_reg;
        tgt_idx_next   = tgt_idx_reg;
        tgt_data_next  = tgt_data_reg;
        pass_next      = pass_reg;
        attr_next      = attr_reg;
        x_lo_next      = x_lo_reg;
        y_lo_next      = y_lo_reg;
        under_next     = under_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        cell_we        = 1'b0;
        cell_waddr     = head.cell_idx;
        cell_wdata     = head.cell_data;
        cell_re        = 1'b0;
        cell_raddr     = head.cell_idx;
        font_we        = 1'b0;
        font_re        = 1'b0;
        font_raddr     = FONT_AW'(32'(cell_q[7:0]) * GLYPH_HEIGHT + 32'(y_lo_reg));
        pop            = 1'b0;
        src            = {1'b0, cnt_reg} + {1'b0, off_reg};
        from_src       = !blank_all_reg && ({{(31-CELL_AW){1'b0}}, src} < CELL_COUNT);
        gbit           = glyph_q[3'(GLYPH_WIDTH - 1) - 3'(x_lo_reg)];

        // second half of the copy pipeline: write what was read last cycle, or a blank cell
        if (wr_pend_reg) begin
            cell_we    = 1'b1;
            cell_waddr = wr_idx_reg;
            cell_wdata = wr_blank_reg ? BLANK_CELL : cell_q;
        end

        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    pop = 1'b1;
                    case (head.kind)
                        KIND_WRITE: begin
                            if (head.scroll) begin
                                off_next       = head.scroll_off;
                                blank_all_next = head.blank_all;
                                tgt_ok_next    = head.wr_ok;
                                tgt_idx_next   = head.cell_idx;
                                tgt_data_next  = head.cell_data;
                                cnt_next       = '0;
                                state_next     = ST_SWEEP;
                            end else begin
                                cell_we = head.wr_ok;
                            end
                        end
                        KIND_CLEAR: begin
                            blank_all_next = 1'b1;
                            tgt_ok_next    = 1'b0;
                            cnt_next       = '0;
                            state_next     = ST_SWEEP;
                        end
                        KIND_FONT: begin
                            font_we = 1'b1;
                        end
                        default: begin
                            cell_re    = 1'b1;
                            pass_next  = head.pass;
                            x_lo_next  = GX_W'(head.pix_x % GLYPH_WIDTH);
                            y_lo_next  = GY_W'(head.pix_y % GLYPH_HEIGHT);
                            under_next = head.under;
                            state_next = ST_CELL;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                cell_re       = from_src;
                cell_raddr    = src[CELL_AW-1:0];
                wr_pend_next  = 1'b1;
                wr_idx_next   = cnt_reg;
                wr_blank_next = !from_src;
                cnt_next      = cnt_reg + 1'b1;
                if ({{(31-CELL_AW){1'b0}}, cnt_reg} == CELL_COUNT - 1) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                init_next  = 1'b0;
                state_next = tgt_ok_reg ? ST_WRITE : ST_IDLE;
            end
            ST_WRITE: begin
                cell_we    = 1'b1;
                cell_waddr = tgt_idx_reg;
                cell_wdata = tgt_data_reg;
                state_next = ST_IDLE;
            end
            ST_CELL: begin
                pass_next  = pass_reg || (cell_q[10:8] == EMPTY_MARK);
                attr_next  = cell_q[9:8];
                font_re    = 1'b1;
                state_next = ST_FONT;
            end
            ST_FONT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (pass_reg) begin
                        m_data_next = under_reg;
                    end else if (gbit && !attr_reg[1]) begin
                        m_data_next = fg_color;
                    end else if (!gbit && !attr_reg[0]) begin
                        m_data_next = bg_color;
                    end else begin
                        m_data_next = under_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
            blank_all_reg <= 1'b1;
            tgt_ok_reg    <= 1'b0;
            wr_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
            blank_all_reg <= blank_all_next;
            tgt_ok_reg    <= tgt_ok_next;
            wr_pend_reg   <= wr_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg      <= off_next;
        wr_idx_reg   <= wr_idx_next;
        wr_blank_reg <= wr_blank_next;
        tgt_idx_reg  <= tgt_idx_next;
        tgt_data_reg <= tgt_data_next;
        pass_reg     <= pass_next;
        attr_reg     <= attr_next;
        x_lo_reg     <= x_lo_next;
        y_lo_reg     <= y_lo_next;
        under_reg    <= under_next;
        m_data_reg   <= m_data_next;
    end

    assign stat.init_busy = init_reg;
    assign stat.pop       = pop;
    assign m_tvalid       = m_valid_reg;
    assign m_tdata        = m_data_reg;

    `TTO_ASSERT_IMP(a_pop_only_idle, pop, state_reg == ST_IDLE && !init_reg)
    `TTO_ASSERT_IMP(a_sweep_writes_behind, wr_pend_reg && state_reg == ST_SWEEP,
        wr_idx_reg < cnt_reg)
    `TTO_ASSERT_NXT(a_result_after_glyph, !m_valid_reg && m_valid_next,
        $past(state_reg) == ST_FONT)
endmodule

// ===== rtl/core/text_terminal_overlay_top.sv =====
// top level of the text overlay: config registers, front end and back end
//
//  port group   dir   handshake          contents
//  s_*          in    s_tvalid/s_tready  tuser kind, tdata item fields
//  m_*          out   m_tvalid/m_tready  tdata pixel_color
//  p*           in    psel/penable       foreground at 0x0, background at 0x4
//
//  render: one pixel at a time via the cell read, font read and color select
//  cell write and font load: done as the item is popped; write with scroll and
//  clear: one cell per cycle through the single write port of the cell store
//  after reset a clearing pass blanks the grid, s_tready is low
//  a 4-entry queue lets input keep arriving while the output waits on m_tready
module text_terminal_overlay_top import tto_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // col[7:0] row[15:8] code[23:16] flags[26:24] faddr[37:27] fbyte[45:38]
    // x[54:46] y[62:55] under[70:63]
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pixel_color
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0] fg_reg, bg_reg;
    logic       head_valid;
    op_t        head;
    back_stat_t stat;

    assign pready = 1'b1;
    assign prdata = {24'd0, paddr[2] ? bg_reg : fg_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= 8'hFF;
            bg_reg <= 8'h00;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) bg_reg <= pwdata[7:0];
            else          fg_reg <= pwdata[7:0];
        end
    end

    tto_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .stat       (stat),
        .head_valid (head_valid),
        .head       (head)
    );

    tto_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .stat       (stat),
        .fg_color   (fg_reg),
        .bg_color   (bg_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );
endmodule
